[src/pitb_pkg.sv]
// Shared constants for the barycentric point-in-triangle unit.
package pitb_pkg;

  // Default coordinate width; valid range is 4 to 32 bits.
  localparam int CoordBitsDef = 16;

endpackage

[src/pitb_if.sv]
// Handshake interfaces for the query and result channels of the triangle test unit.
interface pitb_query_if #(
  parameter int COORD_BITS = pitb_pkg::CoordBitsDef
);
  import pitb_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] query_z;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  logic signed [COORD_BITS-1:0] third_x;
  logic signed [COORD_BITS-1:0] third_y;
  logic signed [COORD_BITS-1:0] third_z;

  modport source (
    output valid, query_x, query_y, query_z, first_x, first_y, first_z,
           second_x, second_y, second_z, third_x, third_y, third_z,
    input  ready
  );

  modport sink (
    input  valid, query_x, query_y, query_z, first_x, first_y, first_z,
           second_x, second_y, second_z, third_x, third_y, third_z,
    output ready
  );
endinterface

interface pitb_result_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (output valid, inside_res, degenerate, input ready);
  modport sink (input valid, inside_res, degenerate, output ready);
endinterface

[src/point_in_triangle_barycentric_unit.sv]
// Top level of the exact barycentric point-in-triangle test.
// Throughput: one item per cycle; a stalled result halts the whole pipeline in place.
// The long pole is the dot-product by dot-product multiply, split over three stages.
// Reset clears only the stage valid bits; data registers hold whatever they had.
module point_in_triangle_barycentric_unit #(
  parameter int COORD_BITS = pitb_pkg::CoordBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pitb_query_if.sink    query_i,
  pitb_result_if.source result_o
);
  import pitb_pkg::*;

  // Edge/offset component width, per-term product width, dot product width,
  // and the width of a product of two dot products.
  localparam int DW        = COORD_BITS + 1;
  localparam int PW        = 2 * DW;
  localparam int DotW      = PW + 2;
  localparam int MW        = 2 * DotW;
  localparam int NumStages = 8;

  // Stage map: 0 edges, 1 term products, 2 dot products, 3..5 multiplier,
  // 6 denominator and numerators, 7 result register.
  logic [NumStages-1:0] vld_q;
  logic                 adv;

  // Advance whenever the result register is empty or being drained.
  assign adv           = !vld_q[NumStages-1] || result_o.ready;
  assign query_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], query_i.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: edge vectors E1 = B - A, E2 = C - A and offset W = Q - A.
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] q_c [3];
  logic signed [COORD_BITS-1:0] a_c [3];
  logic signed [COORD_BITS-1:0] b_c [3];
  logic signed [COORD_BITS-1:0] c_c [3];

  assign q_c[0] = $signed(query_i.query_x[COORD_BITS-1:0]);
  assign q_c[1] = $signed(query_i.query_y[COORD_BITS-1:0]);
  assign q_c[2] = $signed(query_i.query_z[COORD_BITS-1:0]);
  assign a_c[0] = $signed(query_i.first_x[COORD_BITS-1:0]);
  assign a_c[1] = $signed(query_i.first_y[COORD_BITS-1:0]);
  assign a_c[2] = $signed(query_i.first_z[COORD_BITS-1:0]);
  assign b_c[0] = $signed(query_i.second_x[COORD_BITS-1:0]);
  assign b_c[1] = $signed(query_i.second_y[COORD_BITS-1:0]);
  assign b_c[2] = $signed(query_i.second_z[COORD_BITS-1:0]);
  assign c_c[0] = $signed(query_i.third_x[COORD_BITS-1:0]);
  assign c_c[1] = $signed(query_i.third_y[COORD_BITS-1:0]);
  assign c_c[2] = $signed(query_i.third_z[COORD_BITS-1:0]);

  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [DW-1:0] wq_q [3];

  // ---------------------------------------------------------------------
  // Stage 1: the fifteen per-component products feeding the dot products.
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] p00_q [3];
  logic signed [PW-1:0] p01_q [3];
  logic signed [PW-1:0] p11_q [3];
  logic signed [PW-1:0] p20_q [3];
  logic signed [PW-1:0] p21_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    always_ff @(posedge clk_i) begin
      if (adv) begin
        e1_q[k]  <= DW'(b_c[k]) - DW'(a_c[k]);
        e2_q[k]  <= DW'(c_c[k]) - DW'(a_c[k]);
        wq_q[k]  <= DW'(q_c[k]) - DW'(a_c[k]);
        p00_q[k] <= PW'(e1_q[k]) * PW'(e1_q[k]);
        p01_q[k] <= PW'(e1_q[k]) * PW'(e2_q[k]);
        p11_q[k] <= PW'(e2_q[k]) * PW'(e2_q[k]);
        p20_q[k] <= PW'(wq_q[k]) * PW'(e1_q[k]);
        p21_q[k] <= PW'(wq_q[k]) * PW'(e2_q[k]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: three-term sums give d00, d01, d11, d20, d21.
  // ---------------------------------------------------------------------
  logic signed [DotW-1:0] d00_q, d01_q, d11_q, d20_q, d21_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d00_q <= DotW'(p00_q[0]) + DotW'(p00_q[1]) + DotW'(p00_q[2]);
      d01_q <= DotW'(p01_q[0]) + DotW'(p01_q[1]) + DotW'(p01_q[2]);
      d11_q <= DotW'(p11_q[0]) + DotW'(p11_q[1]) + DotW'(p11_q[2]);
      d20_q <= DotW'(p20_q[0]) + DotW'(p20_q[1]) + DotW'(p20_q[2]);
      d21_q <= DotW'(p21_q[0]) + DotW'(p21_q[1]) + DotW'(p21_q[2]);
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3..5: six products of dot products, one split multiplier each.
  // Order: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
  // ---------------------------------------------------------------------
  logic signed [DotW-1:0] mul_a [6];
  logic signed [DotW-1:0] mul_b [6];
  logic signed [MW-1:0]   mul_p [6];

  assign mul_a[0] = d00_q;  assign mul_b[0] = d11_q;
  assign mul_a[1] = d01_q;  assign mul_b[1] = d01_q;
  assign mul_a[2] = d11_q;  assign mul_b[2] = d20_q;
  assign mul_a[3] = d01_q;  assign mul_b[3] = d21_q;
  assign mul_a[4] = d00_q;  assign mul_b[4] = d21_q;
  assign mul_a[5] = d01_q;  assign mul_b[5] = d20_q;

  for (genvar m = 0; m < 6; m++) begin : g_mul
    pitb_mul #(
      .W (DotW)
    ) u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (mul_a[m]),
      .b_i   (mul_b[m]),
      .p_o   (mul_p[m])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 6: Cramer denominator D and the two numerators P and S.
  // ---------------------------------------------------------------------
  logic signed [MW:0] den_q, pn_q, sn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q <= (MW+1)'(mul_p[0]) - (MW+1)'(mul_p[1]);
      pn_q  <= (MW+1)'(mul_p[2]) - (MW+1)'(mul_p[3]);
      sn_q  <= (MW+1)'(mul_p[4]) - (MW+1)'(mul_p[5]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: sign tests stand in for the division by D. Inside or on the
  // triangle when P >= 0, S >= 0 and P + S <= D; a zero D is degenerate
  // and forces the point outside.
  // ---------------------------------------------------------------------
  logic signed [MW+2:0] slack;
  logic                 den_zero;
  logic                 inside_d;
  logic                 inside_q, degen_q;

  always_comb begin
    slack    = (MW+3)'(den_q) - (MW+3)'(pn_q) - (MW+3)'(sn_q);
    den_zero = (den_q == '0);
    inside_d = !den_zero && !pn_q[MW] && !sn_q[MW] && !slack[MW+2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inside_q <= inside_d;
      degen_q  <= den_zero;
    end
  end

  assign result_o.valid      = vld_q[NumStages-1];
  assign result_o.inside_res = inside_q;
  assign result_o.degenerate = degen_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // An accepted item occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_i.valid && query_i.ready |=> vld_q[0])
    else $error("accepted item did not enter the pipeline");

  // An item in the first stage moves on to the second when the pipeline advances.
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[0] |=> vld_q[1])
    else $error("item lost between first and second stage");

  // A stall freezes every valid bit.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

  // A degenerate triangle never reports the point inside.
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.degenerate |-> !result_o.inside_res)
    else $error("degenerate triangle reported as inside");
endmodule

[src/pitb_mul.sv]
// Three-stage signed multiplier built from half-width partial products.
module pitb_mul #(
  parameter int W = 36
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);
  import pitb_pkg::*;

  localparam int LoW = W / 2;
  localparam int HiW = W - LoW;

  logic signed [HiW-1:0]   a_hi, b_hi;
  logic        [LoW-1:0]   a_lo, b_lo;

  logic signed [2*HiW-1:0] hh_d, hh_q;
  logic        [2*LoW-1:0] ll_d, ll_q;
  logic signed [W:0]       c1_d, c1_q, c2_d, c2_q;

  logic signed [2*W-1:0]   hl_d, hl_q;
  logic signed [W+1:0]     mid_d, mid_q;

  logic signed [2*W-1:0]   mid_ext;
  logic signed [2*W-1:0]   p_d, p_q;

  assign a_hi = $signed(a_i[W-1:LoW]);
  assign b_hi = $signed(b_i[W-1:LoW]);
  assign a_lo = a_i[LoW-1:0];
  assign b_lo = b_i[LoW-1:0];

  // Partial products: high x high, low x low, and the two cross terms.
  always_comb begin
    hh_d = (2*HiW)'(a_hi) * (2*HiW)'(b_hi);
    ll_d = (2*LoW)'(a_lo) * (2*LoW)'(b_lo);
    c1_d = (W+1)'(a_hi) * $signed({1'b0, b_lo});
    c2_d = (W+1)'(b_hi) * $signed({1'b0, a_lo});
  end

  // Low product never exceeds its field, so high and low simply abut.
  always_comb begin
    hl_d  = $signed({hh_q, ll_q});
    mid_d = (W+2)'(c1_q) + (W+2)'(c2_q);
  end

  always_comb begin
    mid_ext = (2*W)'(mid_q);
    p_d     = hl_q + (mid_ext <<< LoW);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q  <= hh_d;
      ll_q  <= ll_d;
      c1_q  <= c1_d;
      c2_q  <= c2_d;
      hl_q  <= hl_d;
      mid_q <= mid_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;
endmodule

[bench/point_in_triangle_barycentric_unit_test.sv]
// Self-checking testbench for the barycentric point-in-triangle unit.
`timescale 1ns / 1ps

module point_in_triangle_barycentric_unit_test;
  import pitb_pkg::*;

  localparam int COORD_BITS = CoordBitsDef;
  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int LATENCY = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 425;
  // The slowest correct run ends well inside this limit; keep a wide margin.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int WIDE_BITS = 192;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  typedef struct {
    coord_t query_x, query_y, query_z;
    coord_t first_x, first_y, first_z;
    coord_t second_x, second_y, second_z;
    coord_t third_x, third_y, third_z;
  } tri_query_t;

  typedef struct {
    logic inside_res;
    logic degenerate;
  } tri_verdict_t;

  typedef enum int {ROW_TYPED, ROW_PREDICTED} row_kind_e;
  typedef enum int {STYLE_UNIFORM, STYLE_LATTICE, STYLE_DEGENERATE, STYLE_EXTREME} query_style_e;

  typedef struct {
    tri_query_t   item;
    row_kind_e    kind;
    tri_verdict_t verdict;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pitb_query_if #(.COORD_BITS(COORD_BITS)) query_bus();
  pitb_result_if result_bus();

  point_in_triangle_barycentric_unit #(.COORD_BITS(COORD_BITS)) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .query_i  (query_bus),
    .result_o (result_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  tri_verdict_t  pending_verdicts[$];
  directed_row_t directed_table[$];
  int            verdict_errors = 0;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  bit            hold_off_req = 1'b0;
  int unsigned   cycle_count = 0;

  // Exact integer version of the barycentric test; wide enough that nothing wraps.
  function automatic tri_verdict_t triangle_verdict(input tri_query_t t);
    wide_t q[3], a[3], b[3], c[3];
    wide_t e1[3], e2[3], w[3];
    wide_t d00, d01, d11, d20, d21, den, pn, sn, slack;
    tri_verdict_t v;
    q[0] = t.query_x;  q[1] = t.query_y;  q[2] = t.query_z;
    a[0] = t.first_x;  a[1] = t.first_y;  a[2] = t.first_z;
    b[0] = t.second_x; b[1] = t.second_y; b[2] = t.second_z;
    c[0] = t.third_x;  c[1] = t.third_y;  c[2] = t.third_z;
    for (int k = 0; k < 3; k++) begin
      e1[k] = b[k] - a[k];
      e2[k] = c[k] - a[k];
      w[k]  = q[k] - a[k];
    end
    d00 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
    d01 = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
    d11 = e2[0] * e2[0] + e2[1] * e2[1] + e2[2] * e2[2];
    d20 = w[0] * e1[0] + w[1] * e1[1] + w[2] * e1[2];
    d21 = w[0] * e2[0] + w[1] * e2[1] + w[2] * e2[2];
    den = d00 * d11 - d01 * d01;
    if (den == '0) begin
      v.inside_res = 1'b0;
      v.degenerate = 1'b1;
    end else begin
      pn = d11 * d20 - d01 * d21;
      sn = d00 * d21 - d01 * d20;
      slack = den - (pn + sn);
      // Inside or on: both numerators non-negative and their sum within D.
      v.inside_res = !pn[WIDE_BITS-1] && !sn[WIDE_BITS-1] && !slack[WIDE_BITS-1];
      v.degenerate = 1'b0;
    end
    return v;
  endfunction

  function automatic tri_query_t pack_query(
    input int qx, input int qy, input int qz, input int ax, input int ay, input int az,
    input int bx, input int by, input int bz, input int cx, input int cy, input int cz
  );
    tri_query_t r;
    r.query_x  = coord_t'(qx); r.query_y  = coord_t'(qy); r.query_z  = coord_t'(qz);
    r.first_x  = coord_t'(ax); r.first_y  = coord_t'(ay); r.first_z  = coord_t'(az);
    r.second_x = coord_t'(bx); r.second_y = coord_t'(by); r.second_z = coord_t'(bz);
    r.third_x  = coord_t'(cx); r.third_y  = coord_t'(cy); r.third_z  = coord_t'(cz);
    return r;
  endfunction

  function automatic void add_row(input tri_query_t item, input row_kind_e kind,
                                  input logic inside_res, input logic degenerate);
    directed_row_t row;
    row.item = item;
    row.kind = kind;
    row.verdict.inside_res = inside_res;
    row.verdict.degenerate = degenerate;
    directed_table.insert(directed_table.size(), row);
  endfunction

  // Half are lattice triangles whose queries land on lattice points, among them vertices,
  // edges and points just past them; the rest is noise, collinear sets and extreme corners.
  function automatic tri_query_t random_query();
    int v[12];
    int a[3], e1[3], e2[3], n[3];
    int k, i, j, t, roll, m;
    query_style_e style;
    roll = $urandom_range(99);
    style = (roll < 25) ? STYLE_UNIFORM : (roll < 75) ? STYLE_LATTICE :
            (roll < 85) ? STYLE_DEGENERATE : STYLE_EXTREME;
    for (m = 0; m < 3; m++) begin
      a[m]  = int'($urandom_range(32000)) - 16000;
      e1[m] = int'($urandom_range(120)) - 60;
      e2[m] = int'($urandom_range(120)) - 60;
    end
    k = $urandom_range(8, 1);
    i = $urandom_range(k, 0);
    j = $urandom_range(k, 0);
    for (m = 0; m < 12; m++) v[m] = int'($urandom_range(65535)) - 32768;
    case (style)
      STYLE_LATTICE: begin
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        // Lift the query off the plane along the normal now and then.
        t = ($urandom_range(3) == 0) ? int'($urandom_range(2)) - 1 : 0;
        for (m = 0; m < 3; m++) begin
          v[m]     = a[m] + i * e1[m] + j * e2[m] + t * n[m];
          v[3 + m] = a[m];
          v[6 + m] = a[m] + k * e1[m];
          v[9 + m] = a[m] + k * e2[m];
        end
        if ($urandom_range(3) == 0) v[$urandom_range(2)] += ($urandom_range(1) == 0) ? 1 : -1;
      end
      STYLE_DEGENERATE: begin
        // Collinear along one edge; a zero step makes vertices coincide.
        for (m = 0; m < 3; m++) begin
          v[3 + m] = a[m];
          v[6 + m] = a[m] + i * e1[m];
          v[9 + m] = a[m] + j * e1[m];
        end
      end
      STYLE_EXTREME: begin
        for (m = 0; m < 12; m++) begin
          case ($urandom_range(5))
            0: v[m] = COORD_MIN;
            1: v[m] = COORD_MAX;
            2: v[m] = 0;
            3: v[m] = -1;
            4: v[m] = 1;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return pack_query(v[0], v[1], v[2], v[3], v[4], v[5],
                      v[6], v[7], v[8], v[9], v[10], v[11]);
  endfunction

  // Offer one item after a random gap, hold it until accepted, then record its verdict.
  task automatic offer_query(input tri_query_t t, input tri_verdict_t verdict);
    while ($urandom_range(99) < sender_idle_pct) begin
      query_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    query_bus.query_x  <= t.query_x;  query_bus.query_y  <= t.query_y;
    query_bus.query_z  <= t.query_z;
    query_bus.first_x  <= t.first_x;  query_bus.first_y  <= t.first_y;
    query_bus.first_z  <= t.first_z;
    query_bus.second_x <= t.second_x; query_bus.second_y <= t.second_y;
    query_bus.second_z <= t.second_z;
    query_bus.third_x  <= t.third_x;  query_bus.third_y  <= t.third_y;
    query_bus.third_z  <= t.third_z;
    query_bus.valid    <= 1'b1;
    do @(posedge clk_i); while (query_bus.ready !== 1'b1);
    pending_verdicts.insert(pending_verdicts.size(), verdict);
  endtask

  // Drop valid and wait until every recorded verdict has been matched.
  task automatic drain_pipeline();
    query_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Result sink: random stalls, plus one long hold-off counted here on request.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Compare each accepted result item with the oldest recorded verdict.
  always @(posedge clk_i) begin
    tri_verdict_t want;
    if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        if (verdict_errors < 10) begin
          $display("unexpected result item: inside=%0b degenerate=%0b",
                   result_bus.inside_res, result_bus.degenerate);
        end
        verdict_errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (result_bus.inside_res !== want.inside_res ||
            result_bus.degenerate !== want.degenerate) begin
          if (verdict_errors < 10) begin
            $display("mismatch: expected inside=%0b degenerate=%0b, got inside=%0b degenerate=%0b",
                     want.inside_res, want.degenerate,
                     result_bus.inside_res, result_bus.degenerate);
          end
          verdict_errors++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("point_in_triangle_barycentric_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int sender_idle[4];
    int receiver_stall[4];
    tri_verdict_t verdict;
    tri_query_t q;
    sender_idle    = '{0, 84, 0, 11};
    receiver_stall = '{0, 0, 84, 11};
    rst_ni = 1'b0;
    query_bus.valid = 1'b0;
    query_bus.query_x = '0;  query_bus.query_y = '0;  query_bus.query_z = '0;
    query_bus.first_x = '0;  query_bus.first_y = '0;  query_bus.first_z = '0;
    query_bus.second_x = '0; query_bus.second_y = '0; query_bus.second_z = '0;
    query_bus.third_x = '0;  query_bus.third_y = '0;  query_bus.third_z = '0;

    // Coincident vertices at zero and at both extremes: all degenerate.
    add_row(pack_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), ROW_TYPED, 1'b0, 1'b1);
    add_row(pack_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
            ROW_TYPED, 1'b0, 1'b1);
    add_row(pack_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN),
            ROW_TYPED, 1'b0, 1'b1);
    // Right triangle in the z = 0 plane: interior, outside, vertex, edge, just past.
    add_row(pack_query(10, 10, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0), ROW_TYPED, 1'b1, 1'b0);
    add_row(pack_query(200, 200, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0), ROW_TYPED, 1'b0, 1'b0);
    add_row(pack_query(0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0), ROW_TYPED, 1'b1, 1'b0);
    add_row(pack_query(100, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0), ROW_TYPED, 1'b1, 1'b0);
    add_row(pack_query(50, 50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0), ROW_TYPED, 1'b1, 1'b0);
    add_row(pack_query(51, 50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0), ROW_TYPED, 1'b0, 1'b0);
    add_row(pack_query(-1, 10, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0), ROW_TYPED, 1'b0, 1'b0);
    // Off the plane: only the projection counts.
    add_row(pack_query(10, 10, 5000, 0, 0, 0, 100, 0, 0, 0, 100, 0), ROW_TYPED, 1'b1, 1'b0);
    add_row(pack_query(10, 10, COORD_MIN, 0, 0, 0, 100, 0, 0, 0, 100, 0),
            ROW_TYPED, 1'b1, 1'b0);
    // Collinear and partly coincident vertices.
    add_row(pack_query(1, 1, 1, 0, 0, 0, 1, 1, 1, 2, 2, 2), ROW_TYPED, 1'b0, 1'b1);
    add_row(pack_query(5, 5, 5, 5, 5, 5, 5, 5, 5, 9, -3, 7), ROW_TYPED, 1'b0, 1'b1);
    add_row(pack_query(9, -3, 7, 5, 5, 5, 9, -3, 7, 5, 5, 5), ROW_TYPED, 1'b0, 1'b1);
    // Full-range triangles where the products reach their largest sizes.
    add_row(pack_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN),
            ROW_PREDICTED, 1'b0, 1'b0);
    add_row(pack_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN),
            ROW_PREDICTED, 1'b0, 1'b0);
    add_row(pack_query(0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX),
            ROW_PREDICTED, 1'b0, 1'b0);
    add_row(pack_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX),
            ROW_PREDICTED, 1'b0, 1'b0);
    add_row(pack_query(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                       COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX),
            ROW_PREDICTED, 1'b0, 1'b0);
    add_row(pack_query(-1, -1, -1, 1, -1, 0, -1, 1, 0, 0, 0, 1), ROW_PREDICTED, 1'b0, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table with no idling on either side.
    foreach (directed_table[r]) begin
      verdict = (directed_table[r].kind == ROW_TYPED) ? directed_table[r].verdict
                                                       : triangle_verdict(directed_table[r].item);
      offer_query(directed_table[r].item, verdict);
    end

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = sender_idle[ph];
      receiver_stall_pct = receiver_stall[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Hold off the sink while items keep coming, so the pipe fills and stalls.
        if (ph == 0 && n == 100) hold_off_req = 1'b1;
        // Pause the source until the pipe is empty once.
        if (ph == 0 && n == 300) drain_pipeline();
        q = random_query();
        offer_query(q, triangle_verdict(q));
      end
    end

    drain_pipeline();
    repeat (4 * LATENCY) @(posedge clk_i);
    if (verdict_errors == 0 && pending_verdicts.size() == 0) begin
      $display("point_in_triangle_barycentric_unit verification clean");
    end else begin
      $display("point_in_triangle_barycentric_unit verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/pitb_pkg.sv
src/pitb_if.sv
src/pitb_mul.sv
src/point_in_triangle_barycentric_unit.sv
bench/point_in_triangle_barycentric_unit_test.sv
